>>> rtl/core/convex_polygon_scanline_fill_macros.svh
// Assertion macros used by the top module of the polygon fill block.
`ifndef CONVEX_POLYGON_SCANLINE_FILL_MACROS_SVH
`define CONVEX_POLYGON_SCANLINE_FILL_MACROS_SVH

`ifndef SYNTH
`define CPSF_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("cpsf assertion failed");
`define CPSF_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("cpsf forbidden condition seen");
`else
`define CPSF_ASSERT(lbl, clk, rst_n, prop)
`define CPSF_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

>>> rtl/core/cpsf_pkg.sv
package cpsf_pkg;

  localparam int GRID_SIZE_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int FIELD_W       = 5;
  localparam int SPAN_W        = 10;

  typedef struct packed {
    logic [FIELD_W-1:0] xb;
    logic [FIELD_W-1:0] yb;
    logic [FIELD_W-1:0] xt;
    logic [FIELD_W-1:0] yt;
  } edge_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
    logic rd_slot;
    logic clr;
  } tab_ctrl_t;

endpackage

>>> rtl/core/convex_polygon_scanline_fill.sv
// Convex polygon scanline fill.
// Edges of one polygon enter on the command port: an edge is taken at a
// rising edge where start_i is high and busy_o is low. An edge that is not
// the last one is stored in the edge table in that cycle if its rows lie in
// the grid; busy_o stays low and the next edge may follow in the next cycle.
// The edge marked by last_edge_i is stored as well and starts the fill. busy_o
// then stays high while the rows from the lowest bottom row up to the highest
// top row, excluding it, are walked. Each row yields one span transfer, shown
// for one cycle with span_valid_o high; last_span_o marks the final one.
// A row passes the states S_ROW, S_ROW_R and S_EMIT, and each active edge
// that ends there is reloaded; the slope of every new edge comes from one
// shared restoring divider that yields one quotient bit per cycle. The fill
// starts with the loads of the left and right edges of the lowest row, and
// the walk ends by emptying the table.
// The receiver cannot hold spans off; every span is valid for one cycle only.
// Reset empties the edge table, clears the active edges and resets the row bounds.
// The edge table is emptied again at the end of every fill.
module convex_polygon_scanline_fill #(
  parameter int GRID_SIZE = cpsf_pkg::GRID_SIZE_DEF,
  parameter int FRAC_BITS = cpsf_pkg::FRAC_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [4:0]  x_bottom_i,
  input  logic [4:0]  y_bottom_i,
  input  logic [4:0]  x_top_i,
  input  logic [4:0]  y_top_i,
  input  logic [23:0] fill_colour_i,
  input  logic        last_edge_i,
  output logic        span_valid_o,
  output logic [4:0]  span_row_o,
  output logic [4:0]  span_first_o,
  output logic [4:0]  span_last_o,
  output logic        span_present_o,
  output logic [23:0] span_colour_o,
  output logic        last_span_o
);

`include "convex_polygon_scanline_fill_macros.svh"

  localparam int RW = $clog2(GRID_SIZE);
  localparam int XW = FRAC_BITS + 6;
  localparam int IW = cpsf_pkg::SPAN_W;
  localparam logic signed [IW-1:0] GRID_MAX = IW'(GRID_SIZE - 1);
  localparam logic [XW:0] ROUND_UP = (XW+1)'((1 << FRAC_BITS) - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_IL_RD, S_IR_RD, S_LOAD, S_DIV, S_ROW, S_ROW_R, S_EMIT
  } state_e;

  state_e          state_q, ret_q;
  logic            tgt_q;
  logic [RW-1:0]   y_q, low_q, high_q;
  cpsf_pkg::edge_t left_q, right_q;
  logic [XW-1:0]   lx_q, rx_q, sl_q, sr_q;
  logic [23:0]     colour_q;
  logic            accept, in_range, div_start, div_done, rd_v1;
  logic [XW-1:0]   quo;
  logic [RW-1:0]   in_row, in_top, rd_row;
  cpsf_pkg::edge_t in_edge, rd_edge;
  cpsf_pkg::tab_ctrl_t ctrl;
  logic signed [5:0] dx, dy;
  logic [XW:0]     l_ceil;
  logic signed [IW-1:0] first_s, last_s, first_c, last_c;
  logic            adj, present;

  assign accept   = start_i && (state_q == S_IDLE);
  assign busy_o   = (state_q != S_IDLE);
  assign in_range = (int'(y_bottom_i) < GRID_SIZE) && (int'(y_top_i) < GRID_SIZE);
  assign in_row   = RW'(y_bottom_i);
  assign in_top   = RW'(y_top_i);
  assign in_edge  = '{xb: x_bottom_i, yb: y_bottom_i, xt: x_top_i, yt: y_top_i};

  always_comb begin
    ctrl.wr_en   = accept && in_range;
    ctrl.rd_en   = 1'b0;
    ctrl.rd_slot = 1'b0;
    ctrl.clr     = 1'b0;
    rd_row       = y_q;
    unique case (state_q)
      S_IL_RD: begin
        ctrl.rd_en = 1'b1;
        rd_row     = low_q;
      end
      S_IR_RD: begin
        ctrl.rd_en   = 1'b1;
        ctrl.rd_slot = 1'b1;
        rd_row       = low_q;
      end
      S_ROW: begin
        ctrl.rd_en = 1'b1;
        ctrl.clr   = (y_q >= high_q);
      end
      S_ROW_R: begin
        ctrl.rd_en   = 1'b1;
        ctrl.rd_slot = rd_v1;
      end
      default: begin
      end
    endcase
  end

  cpsf_edge_tab #(
    .GRID_SIZE(GRID_SIZE),
    .RW       (RW)
  ) u_tab (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .wr_row_i (in_row),
    .wr_edge_i(in_edge),
    .rd_row_i (rd_row),
    .rd_v1_o  (rd_v1),
    .rd_edge_o(rd_edge)
  );

  assign div_start = (state_q == S_LOAD);
  assign dx = $signed({1'b0, rd_edge.xt}) - $signed({1'b0, rd_edge.xb});
  assign dy = $signed({1'b0, rd_edge.yt}) - $signed({1'b0, rd_edge.yb});

  cpsf_div #(
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .dx_i   (dx),
    .dy_i   (dy),
    .done_o (div_done),
    .quo_o  (quo)
  );

  assign l_ceil  = {lx_q[XW-1], lx_q} + ROUND_UP;
  assign first_s = IW'($signed(l_ceil[XW:FRAC_BITS]));
  assign adj     = (rx_q[FRAC_BITS-1:0] == '0) && (lx_q != rx_q);
  assign last_s  = IW'($signed(rx_q[XW-1:FRAC_BITS])) - (adj ? IW'(1) : IW'(0));
  assign first_c = (first_s < 0) ? '0 : first_s;
  assign last_c  = (last_s > GRID_MAX) ? GRID_MAX : last_s;
  assign present = (first_c <= last_c);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      ret_q          <= S_IDLE;
      tgt_q          <= 1'b0;
      y_q            <= '0;
      low_q          <= RW'(GRID_SIZE - 1);
      high_q         <= '0;
      left_q         <= '0;
      right_q        <= '0;
      lx_q           <= '0;
      rx_q           <= '0;
      sl_q           <= '0;
      sr_q           <= '0;
      colour_q       <= '0;
      span_valid_o   <= 1'b0;
      span_row_o     <= '0;
      span_first_o   <= '0;
      span_last_o    <= '0;
      span_present_o <= 1'b0;
      span_colour_o  <= '0;
      last_span_o    <= 1'b0;
    end else begin
      span_valid_o <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (in_range) begin
              if (in_row < low_q) begin
                low_q <= in_row;
              end
              if (in_top > high_q) begin
                high_q <= in_top;
              end
            end
            if (last_edge_i) begin
              colour_q <= fill_colour_i;
              state_q  <= S_IL_RD;
            end
          end
        end
        S_IL_RD: begin
          tgt_q   <= 1'b0;
          ret_q   <= S_IR_RD;
          state_q <= S_LOAD;
        end
        S_IR_RD: begin
          tgt_q   <= 1'b1;
          ret_q   <= S_ROW;
          y_q     <= low_q;
          state_q <= S_LOAD;
        end
        S_LOAD: begin
          if (tgt_q) begin
            right_q <= rd_edge;
            rx_q    <= XW'(rd_edge.xb) << FRAC_BITS;
          end else begin
            left_q <= rd_edge;
            lx_q   <= XW'(rd_edge.xb) << FRAC_BITS;
          end
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            if (tgt_q) begin
              sr_q <= quo;
            end else begin
              sl_q <= quo;
            end
            state_q <= ret_q;
          end
        end
        S_ROW: begin
          if (y_q >= high_q) begin
            low_q   <= RW'(GRID_SIZE - 1);
            high_q  <= '0;
            state_q <= S_IDLE;
          end else if (int'(left_q.yt) == int'(y_q)) begin
            tgt_q   <= 1'b0;
            ret_q   <= S_ROW_R;
            state_q <= S_LOAD;
          end else begin
            state_q <= S_ROW_R;
          end
        end
        S_ROW_R: begin
          if (int'(right_q.yt) == int'(y_q)) begin
            tgt_q   <= 1'b1;
            ret_q   <= S_EMIT;
            state_q <= S_LOAD;
          end else begin
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          span_valid_o   <= 1'b1;
          span_row_o     <= 5'(y_q);
          span_first_o   <= present ? first_c[4:0] : '0;
          span_last_o    <= present ? last_c[4:0] : '0;
          span_present_o <= present;
          span_colour_o  <= colour_q;
          last_span_o    <= (y_q + 1'b1 == high_q);
          lx_q           <= lx_q + sl_q;
          rx_q           <= rx_q + sr_q;
          y_q            <= y_q + 1'b1;
          state_q        <= S_ROW;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  `CPSF_ASSERT(a_span_busy, clk_i, rst_ni, span_valid_o |-> busy_o)
  `CPSF_ASSERT(a_last_starts, clk_i, rst_ni, (accept && last_edge_i) |=> busy_o)
  `CPSF_NEVER(a_div_place, clk_i, rst_ni, div_done && (state_q != S_DIV))
  `CPSF_ASSERT(a_last_flag, clk_i, rst_ni, last_span_o && span_valid_o |=> !span_valid_o)

endmodule

>>> rtl/core/cpsf_div.sv
module cpsf_div #(
  parameter int FRAC_BITS = cpsf_pkg::FRAC_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [5:0]       dx_i,
  input  logic signed [5:0]       dy_i,
  output logic                    done_o,
  output logic [FRAC_BITS+5:0]    quo_o
);

  localparam int NW = FRAC_BITS + 5;
  localparam int XW = FRAC_BITS + 6;
  localparam int CW = $clog2(NW + 1);

  logic          run_q, done_q, neg_q, zero_q;
  logic [CW-1:0] cnt_q;
  logic [4:0]    rem_q, den_q;
  logic [NW-1:0] num_q;
  logic [5:0]    dx_abs, dy_abs, t;
  logic          ge;
  logic [XW-1:0] ext;

  assign dx_abs = dx_i[5] ? 6'(-dx_i) : dx_i;
  assign dy_abs = dy_i[5] ? 6'(-dy_i) : dy_i;
  assign t      = {rem_q, num_q[NW-1]};
  assign ge     = t >= {1'b0, den_q};
  assign ext    = {1'b0, num_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      neg_q  <= 1'b0;
      zero_q <= 1'b0;
      rem_q  <= '0;
      den_q  <= '0;
      num_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q  <= 1'b1;
        cnt_q  <= CW'(NW);
        neg_q  <= dx_i[5] ^ dy_i[5];
        zero_q <= (dy_i == 6'sd0);
        rem_q  <= '0;
        den_q  <= dy_abs[4:0];
        num_q  <= {dx_abs[4:0], {FRAC_BITS{1'b0}}};
      end else if (run_q) begin
        rem_q <= ge ? 5'(t - {1'b0, den_q}) : t[4:0];
        num_q <= {num_q[NW-2:0], ge};
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = zero_q ? '0 : (neg_q ? XW'(~ext + 1'b1) : ext);

endmodule

>>> rtl/core/cpsf_edge_tab.sv
module cpsf_edge_tab #(
  parameter int GRID_SIZE = cpsf_pkg::GRID_SIZE_DEF,
  parameter int RW        = $clog2(GRID_SIZE)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cpsf_pkg::tab_ctrl_t ctrl_i,
  input  logic [RW-1:0]       wr_row_i,
  input  cpsf_pkg::edge_t     wr_edge_i,
  input  logic [RW-1:0]       rd_row_i,
  output logic                rd_v1_o,
  output cpsf_pkg::edge_t     rd_edge_o
);

  cpsf_pkg::edge_t mem [2*GRID_SIZE];
  logic [GRID_SIZE-1:0] v0_q, v1_q;
  cpsf_pkg::edge_t rd_q;
  logic rd_ok_q;
  logic wr_slot, rd_ok;

  assign wr_slot = v0_q[wr_row_i];
  assign rd_v1_o = v1_q[rd_row_i];
  assign rd_ok   = ctrl_i.rd_slot ? v1_q[rd_row_i] : v0_q[rd_row_i];

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem[{wr_row_i, wr_slot}] <= wr_edge_i;
    end
    if (ctrl_i.rd_en) begin
      rd_q <= mem[{rd_row_i, ctrl_i.rd_slot}];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q    <= '0;
      v1_q    <= '0;
      rd_ok_q <= 1'b0;
    end else begin
      if (ctrl_i.rd_en) begin
        rd_ok_q <= rd_ok;
      end
      if (ctrl_i.clr) begin
        v0_q <= '0;
        v1_q <= '0;
      end else if (ctrl_i.wr_en) begin
        if (wr_slot) begin
          v1_q[wr_row_i] <= 1'b1;
        end else begin
          v0_q[wr_row_i] <= 1'b1;
        end
      end
    end
  end

  assign rd_edge_o = rd_ok_q ? rd_q : '0;

endmodule
